@@ hw/rtl/smr_pkg.sv @@
// shared constants for the scaled multiply-divide unit
package smr_pkg;

	localparam int OUT_W = 32;

	localparam logic [1:0] REQ_SCALE  = 2'd0;
	localparam logic [1:0] REQ_DIV    = 2'd1;
	localparam logic [1:0] REQ_MULT   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] RND_ZERO   = 2'd0;
	localparam logic [1:0] RND_FLOOR  = 2'd1;
	localparam logic [1:0] RND_CEIL   = 2'd2;
	localparam logic [1:0] RND_UNUSED = 2'd3;

endpackage

@@ hw/rtl/smr_div_pipe.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
module smr_div_pipe #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quot,
	output logic          rem_nz,
	output logic [SW-1:0] side_out
);
	import smr_pkg::*;

	logic          v_s   [NW+1];
	logic [NW-1:0] nq_s  [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [DW-1:0] d_s   [NW+1];
	logic [SW-1:0] sd_s  [NW+1];

	assign v_s[0]   = in_valid;
	assign nq_s[0]  = num;
	assign rem_s[0] = '0;
	assign d_s[0]   = den;
	assign sd_s[0]  = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] cat;
		logic        ge;
		logic [DW:0] diff;
		assign cat  = {rem_s[i], nq_s[i][NW-1]};
		assign ge   = cat >= {1'b0, d_s[i]};
		assign diff = cat - {1'b0, d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[i+1]  <= {nq_s[i][NW-2:0], ge};
				rem_s[i+1] <= ge ? diff[DW-1:0] : cat[DW-1:0];
				d_s[i+1]   <= d_s[i];
				sd_s[i+1]  <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quot      = nq_s[NW];
	assign rem_nz    = rem_s[NW] != '0;
	assign side_out  = sd_s[NW];

endmodule

@@ hw/rtl/scaled_muldiv_rounding.sv @@
// top level of the scaled multiply-divide unit with rounding modes
//
// Request channel (req_valid/req_stall) carries req_type, round_mode and the
// three operands; result channel (res_valid/res_stall) carries result_value,
// div_by_zero and overflowed. One result beat per request beat, in order.
// Operands are the low DATA_WIDTH bits of their fields, two's complement.
// Stages: an input stage with the a*b multiplier, a sign/magnitude stage,
// one restoring divider stage per numerator bit, two rounding stages, the
// multiple multiplier stage and the saturating output register.
// Throughput is one beat per cycle while res_stall does not hold the
// pipeline; the divider chain sets the latency.
// While res_valid is high and res_stall is high the whole pipeline holds
// and req_stall is raised; nothing is lost or repeated.
// Reset clears every valid bit; the block takes a beat in the first cycle
// after reset is released.
module scaled_muldiv_rounding #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  round_mode,
	input  logic [31:0] value_in,
	input  logic [31:0] factor_or_divisor,
	input  logic [31:0] scale_divisor,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] result_value,
	output logic        div_by_zero,
	output logic        overflowed
);
	import smr_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int NW = 2 * W;
	localparam int QW = NW + 2;

	typedef struct packed {
		logic [1:0]     req;
		logic [1:0]     mode;
		logic           qneg;
		logic           dz;
		logic           zr;
		logic [W-1:0]   b;
	} side_t;

	localparam int SW = $bits(side_t);

	logic en;
	assign en        = !(res_valid && res_stall);
	assign req_stall = !en;

	// input stage
	logic                v_s1;
	logic [1:0]          req_s1, mode_s1;
	logic signed [W-1:0] a_s1, b_s1, c_s1;
	logic signed [NW-1:0] prod_s1;
	logic signed [W-1:0] a_in, b_in;
	assign a_in = signed'(value_in[W-1:0]);
	assign b_in = signed'(factor_or_divisor[W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= req_type;
			mode_s1 <= round_mode;
			a_s1    <= a_in;
			b_s1    <= b_in;
			c_s1    <= signed'(scale_divisor[W-1:0]);
			prod_s1 <= NW'(a_in) * NW'(b_in);
		end
	end

	// sign and magnitude
	logic signed [NW-1:0] n_sel;
	logic signed [W-1:0]  d_sel;
	logic                 dz_sel, zr_sel;
	always_comb begin
		n_sel  = NW'(a_s1);
		d_sel  = b_s1;
		if (req_s1 == REQ_SCALE) begin
			n_sel = prod_s1;
			d_sel = c_s1;
		end
		dz_sel = (req_s1 != REQ_UNUSED) && (d_sel == '0);
		zr_sel = (req_s1 == REQ_UNUSED) || dz_sel;
	end

	logic          v_s2;
	logic [NW-1:0] nmag_s2;
	logic [W-1:0]  dmag_s2;
	side_t         sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s2      <= n_sel[NW-1] ? -n_sel : n_sel;
			dmag_s2      <= d_sel[W-1] ? -d_sel : d_sel;
			sd_s2.req    <= req_s1;
			sd_s2.mode   <= mode_s1;
			sd_s2.qneg   <= n_sel[NW-1] ^ d_sel[W-1];
			sd_s2.dz     <= dz_sel;
			sd_s2.zr     <= zr_sel;
			sd_s2.b      <= b_s1;
		end
	end

	// divider chain
	logic          dv_v;
	logic [NW-1:0] dv_q;
	logic          dv_rnz;
	logic [SW-1:0] dv_side;
	side_t         sd_dv;

	smr_div_pipe #(.NW(NW), .DW(W), .SW(SW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (nmag_s2),
		.den       (dmag_s2),
		.side_in   (sd_s2),
		.out_valid (dv_v),
		.quot      (dv_q),
		.rem_nz    (dv_rnz),
		.side_out  (dv_side)
	);
	assign sd_dv = side_t'(dv_side);

	// rounding step on the magnitude
	logic inc;
	assign inc = dv_rnz && (((sd_dv.mode == RND_FLOOR) && sd_dv.qneg)
		|| ((sd_dv.mode == RND_CEIL) && !sd_dv.qneg));

	logic          v_s3;
	logic [NW:0]   qmag_s3;
	side_t         sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qmag_s3 <= (NW+1)'(dv_q) + (NW+1)'(inc);
			sd_s3   <= sd_dv;
		end
	end

	// apply sign
	logic                 v_s4;
	logic signed [QW-1:0] q_s4;
	side_t                sd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4  <= sd_s3.qneg ? -QW'(qmag_s3) : QW'(qmag_s3);
			sd_s4 <= sd_s3;
		end
	end

	// back to a multiple of b
	logic signed [W:0]    qs;
	logic signed [2*W:0]  mprod;
	assign qs    = q_s4[W:0];
	assign mprod = (2*W+1)'(qs) * (2*W+1)'(signed'(sd_s4.b));

	logic                 v_s5;
	logic signed [QW-1:0] val_s5;
	logic                 dz_s5, zr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s5 <= (sd_s4.req == REQ_MULT) ? QW'(mprod) : q_s4;
			dz_s5  <= sd_s4.dz;
			zr_s5  <= sd_s4.zr;
		end
	end

	// saturate into the output register
	localparam logic signed [QW-1:0] MAXV = QW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [QW-1:0] MINV = -MAXV - QW'(1);

	logic signed [W-1:0] sat;
	logic                sat_ov;
	always_comb begin
		sat    = val_s5[W-1:0];
		sat_ov = 1'b0;
		if (zr_s5) begin
			sat = '0;
		end else if (val_s5 > MAXV) begin
			sat    = MAXV[W-1:0];
			sat_ov = 1'b1;
		end else if (val_s5 < MINV) begin
			sat    = MINV[W-1:0];
			sat_ov = 1'b1;
		end
	end

	logic signed [W-1:0] res_q;
	logic                dz_q, ov_q, rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (en) begin
			rv_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sat;
			dz_q  <= dz_s5;
			ov_q  <= sat_ov;
		end
	end

	assign res_valid    = rv_q;
	assign result_value = OUT_W'(res_q);
	assign div_by_zero  = dz_q;
	assign overflowed   = ov_q;

endmodule

@@ verif/tb_scaled_muldiv_rounding.sv @@
// self-checking testbench for the scaled multiply-divide unit with rounding modes
module tb_scaled_muldiv_rounding;
	import smr_pkg::*;

	localparam int N_RANDOM = 1630;
	localparam int LAT = 70;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;
	localparam logic [31:0] MAX32 = 32'h7fffffff;
	localparam logic [31:0] MIN32 = 32'h80000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  mode;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        dz;
		logic        ov;
	} res_t;

	typedef struct packed {
		req_t        rq;
		logic        typed;
		logic [31:0] value;
		logic        dz;
		logic        ov;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  req_type;
	logic [1:0]  round_mode;
	logic [31:0] value_in;
	logic [31:0] factor_or_divisor;
	logic [31:0] scale_divisor;
	logic        res_valid;
	logic        res_stall;
	logic [31:0] result_value;
	logic        div_by_zero;
	logic        overflowed;

	res_t   pending_results[$];
	int     errors = 0;
	int     cycles = 0;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_off;
	bit     stim_done;

	scaled_muldiv_rounding dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.round_mode(round_mode),
		.value_in(value_in),
		.factor_or_divisor(factor_or_divisor),
		.scale_divisor(scale_divisor),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result_value(result_value),
		.div_by_zero(div_by_zero),
		.overflowed(overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint rounded_quotient(longint n, longint d, logic [1:0] mode);
		longint q;
		longint r;
		bit same;
		q = n / d;
		r = n % d;
		if (r != 0) begin
			same = (r < 0) == (d < 0);
			if (mode == RND_FLOOR && !same)
				q = q - 1;
			else if (mode == RND_CEIL && same)
				q = q + 1;
		end
		return q;
	endfunction

	function automatic res_t muldiv_result(req_t rq);
		res_t o;
		longint a;
		longint b;
		longint c;
		longint r;
		a = longint'(signed'(rq.a));
		b = longint'(signed'(rq.b));
		c = longint'(signed'(rq.c));
		r = 0;
		o = '0;
		case (rq.kind)
			REQ_SCALE: begin
				if (c == 0) o.dz = 1'b1;
				else r = rounded_quotient(a * b, c, rq.mode);
			end
			REQ_DIV: begin
				if (b == 0) o.dz = 1'b1;
				else r = rounded_quotient(a, b, rq.mode);
			end
			REQ_MULT: begin
				if (b == 0) o.dz = 1'b1;
				else r = b * rounded_quotient(a, b, rq.mode);
			end
			default: r = 0;
		endcase
		if (r > MAXV) begin
			r = MAXV;
			o.ov = 1'b1;
		end else if (r < MINV) begin
			r = MINV;
			o.ov = 1'b1;
		end
		o.value = r[31:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 9))
			0: return MAX32;
			1: return MIN32;
			2: return 32'd0;
			3: return 32'($urandom_range(0, 20)) - 32'd10;
			4: return 32'($urandom_range(0, 2000)) - 32'd1000;
			5: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_beat(req_t rq);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rq.kind;
		round_mode <= rq.mode;
		value_in <= rq.a;
		factor_or_divisor <= rq.b;
		scale_divisor <= rq.c;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(muldiv_result(rq));
		@(negedge clk);
	endtask

	// accept and check result beats
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", result_value, 32'd0);
			end else begin
				res_t want;
				want = pending_results.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (div_by_zero !== want.dz)
					report_mismatch("div_by_zero", 32'(div_by_zero), 32'(want.dz));
				if (overflowed !== want.ov)
					report_mismatch("overflowed", 32'(overflowed), 32'(want.ov));
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_off)
			res_stall <= 1'b1;
		else
			res_stall <= recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct;
	end

	// long hold-off so the pipeline fills and backs up
	initial begin
		hold_off = 1'b0;
		wait (stim_done == 1'b0 && cycles > 1000);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		req_t rq;
		res_t want;
		int phase_len;
		stim_done = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		res_stall = 1'b0;
		req_type = REQ_SCALE;
		round_mode = RND_ZERO;
		value_in = '0;
		factor_or_divisor = '0;
		scale_divisor = '0;

		// kind, mode, a, b, c, typed, value, dz, ov
		rows = '{
			'{'{REQ_SCALE, RND_ZERO, 32'd7, 32'd3, 32'd0}, 1'b1, 32'd0, 1'b1, 1'b0},
			'{'{REQ_DIV, RND_FLOOR, 32'd7, 32'd0, 32'd5}, 1'b1, 32'd0, 1'b1, 1'b0},
			'{'{REQ_MULT, RND_CEIL, 32'd7, 32'd0, 32'd5}, 1'b1, 32'd0, 1'b1, 1'b0},
			'{'{REQ_UNUSED, RND_ZERO, 32'd7, 32'd2, 32'd1}, 1'b1, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_ZERO, MIN32, 32'hffffffff, 32'd1}, 1'b1, MAX32, 1'b0, 1'b1},
			'{'{REQ_SCALE, RND_ZERO, MAX32, MAX32, 32'd1}, 1'b1, MAX32, 1'b0, 1'b1},
			'{'{REQ_SCALE, RND_ZERO, MIN32, MAX32, 32'd1}, 1'b1, MIN32, 1'b0, 1'b1},
			'{'{REQ_SCALE, RND_CEIL, MIN32, MIN32, MIN32}, 1'b1, MIN32, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_ZERO, 32'd7, 32'd2, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_FLOOR, 32'd7, 32'hfffffffe, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_CEIL, 32'd7, 32'hfffffffe, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_CEIL, 32'hfffffff9, 32'd2, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_UNUSED, 32'hfffffff9, 32'd2, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_MULT, RND_FLOOR, 32'd7, 32'hfffffffd, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_MULT, RND_CEIL, MAX32, 32'h40000000, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_MULT, RND_FLOOR, MIN32, 32'h7ffffffe, 32'd0}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_SCALE, RND_FLOOR, 32'hffffffff, 32'd5, 32'hfffffffd}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_SCALE, RND_CEIL, 32'd100000, 32'd300000, 32'hfffffff9}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_SCALE, RND_UNUSED, MAX32, MAX32, MAX32}, 1'b0, 32'd0, 1'b0, 1'b0},
			'{'{REQ_DIV, RND_ZERO, 32'hffffffff, 32'hffffffff, 32'hffffffff}, 1'b0, 32'd0, 1'b0, 1'b0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			rw = rows[i];
			want = muldiv_result(rw.rq);
			if (rw.typed && want != res_t'{rw.value, rw.dz, rw.ov})
				report_mismatch("table row", 32'(i), want.value);
			send_beat(rw.rq);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			phase_len = N_RANDOM / 3;
			if (i == 0) begin
				send_idle_pct = 26;
				recv_idle_pct = 53;
			end else if (i == phase_len) begin
				send_idle_pct = 53;
				recv_idle_pct = 26;
			end else if (i == 2 * phase_len) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			rq.kind = ($urandom_range(0, 19) == 0) ? REQ_UNUSED : 2'($urandom_range(0, 2));
			rq.mode = 2'($urandom_range(0, 3));
			rq.a = random_operand();
			rq.b = random_operand();
			rq.c = random_operand();
			send_beat(rq);
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
